>>> rtl/core/pbp_pkg.sv
package pbp_pkg;

    // parser phase
    typedef enum logic [1:0] {
        PH_HDR_LO = 2'd0,
        PH_HDR_HI = 2'd1,
        PH_SKIP   = 2'd2,
        PH_DATA   = 2'd3
    } t_phase;

    // colour component expected next
    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE  = 2'd2;

    // event codes
    localparam logic EV_ENTRY     = 1'b0;
    localparam logic EV_BLOCK_END = 1'b1;

    // special record headers
    localparam logic [15:0] HDR_SKIP = 16'h0100;
    localparam logic [15:0] HDR_END  = 16'hFFFF;

    localparam logic [1:0] SKIP_BYTES     = 2'd3;
    localparam logic [8:0] FULL_PALETTE   = 9'd256;

    typedef struct packed {
        logic       event_res;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_result;

    // widen a 6-bit style component to 8 bits
    function automatic logic [7:0] widen(input logic [7:0] b);
        return {b[5:0], 2'b00} | {2'b00, b[7:2]};
    endfunction

endpackage

>>> rtl/core/pbp_if.sv
interface pbp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface pbp_event_if;
    logic       valid;
    logic       ready;
    logic       event_res;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (
        output valid, output event_res, output entry_index,
        output red, output green, output blue, input ready
    );
    modport sink (
        input valid, input event_res, input entry_index,
        input red, input green, input blue, output ready
    );
endinterface

>>> rtl/core/pbp_in_stage.sv
module pbp_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_data_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready     = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_data_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_data_byte;
        end
    end

endmodule

>>> rtl/core/pbp_parser.sv
module pbp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_data_byte,
    output logic             o_res_valid,
    output pbp_pkg::t_result o_res
);

    pbp_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_header_low, n_header_low;
    logic [1:0] r_skip_left, n_skip_left;
    logic [8:0] r_entries_left, n_entries_left;
    logic [7:0] r_next_index, n_next_index;
    logic [1:0] r_comp_pos, n_comp_pos;
    logic [7:0] r_held_red, n_held_red;
    logic [7:0] r_held_green, n_held_green;

    logic [15:0] header;
    logic [7:0]  wide;

    assign header = {i_data_byte, r_header_low};
    assign wide   = pbp_pkg::widen(i_data_byte);

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_header_low   = r_header_low;
        n_skip_left    = r_skip_left;
        n_entries_left = r_entries_left;
        n_next_index   = r_next_index;
        n_comp_pos     = r_comp_pos;
        n_held_red     = r_held_red;
        n_held_green   = r_held_green;
        if (i_fire) begin
            unique case (r_phase)
                pbp_pkg::PH_HDR_LO: begin
                    n_header_low = i_data_byte;
                    n_phase      = pbp_pkg::PH_HDR_HI;
                end
                pbp_pkg::PH_HDR_HI: begin
                    if (header == pbp_pkg::HDR_SKIP) begin
                        n_skip_left = pbp_pkg::SKIP_BYTES;
                        n_phase     = pbp_pkg::PH_SKIP;
                    end else if (header == pbp_pkg::HDR_END) begin
                        n_phase = pbp_pkg::PH_HDR_LO;
                    end else begin
                        n_entries_left = (i_data_byte == 8'd0) ? pbp_pkg::FULL_PALETTE
                                                               : {1'b0, i_data_byte};
                        n_next_index   = r_header_low;
                        n_comp_pos     = pbp_pkg::COMP_RED;
                        n_phase        = pbp_pkg::PH_DATA;
                    end
                end
                pbp_pkg::PH_SKIP: begin
                    if (r_skip_left <= 2'd1) begin
                        n_skip_left = 2'd0;
                        n_phase     = pbp_pkg::PH_HDR_LO;
                    end else begin
                        n_skip_left = r_skip_left - 2'd1;
                    end
                end
                pbp_pkg::PH_DATA: begin
                    if (r_comp_pos == pbp_pkg::COMP_GREEN) begin
                        n_held_green = wide;
                        n_comp_pos   = pbp_pkg::COMP_BLUE;
                    end else if (r_comp_pos != pbp_pkg::COMP_BLUE) begin
                        // unused position 3 falls back to red
                        n_held_red = wide;
                        n_comp_pos = pbp_pkg::COMP_GREEN;
                    end else begin
                        n_next_index = r_next_index + 8'd1;
                        n_comp_pos   = pbp_pkg::COMP_RED;
                        if (r_entries_left <= 9'd1) begin
                            n_entries_left = 9'd0;
                            n_phase        = pbp_pkg::PH_HDR_LO;
                        end else begin
                            n_entries_left = r_entries_left - 9'd1;
                        end
                    end
                end
                default: n_phase = pbp_pkg::PH_HDR_LO;
            endcase
        end
    end

    // result
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_fire) begin
            unique case (r_phase) inside
                pbp_pkg::PH_HDR_HI: begin
                    if (header == pbp_pkg::HDR_END) begin
                        o_res_valid     = 1'b1;
                        o_res.event_res = pbp_pkg::EV_BLOCK_END;
                    end
                end
                pbp_pkg::PH_DATA: begin
                    if (r_comp_pos == pbp_pkg::COMP_BLUE) begin
                        o_res_valid       = 1'b1;
                        o_res.event_res   = pbp_pkg::EV_ENTRY;
                        o_res.entry_index = r_next_index;
                        o_res.red         = r_held_red;
                        o_res.green       = r_held_green;
                        o_res.blue        = wide;
                    end
                end
                pbp_pkg::PH_HDR_LO, pbp_pkg::PH_SKIP: begin
                    o_res_valid = 1'b0;
                end
                default: o_res_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= pbp_pkg::PH_HDR_LO;
            r_header_low   <= 8'd0;
            r_skip_left    <= 2'd0;
            r_entries_left <= 9'd0;
            r_next_index   <= 8'd0;
            r_comp_pos     <= pbp_pkg::COMP_RED;
            r_held_red     <= 8'd0;
            r_held_green   <= 8'd0;
        end else begin
            r_phase        <= n_phase;
            r_header_low   <= n_header_low;
            r_skip_left    <= n_skip_left;
            r_entries_left <= n_entries_left;
            r_next_index   <= n_next_index;
            r_comp_pos     <= n_comp_pos;
            r_held_red     <= n_held_red;
            r_held_green   <= n_held_green;
        end
    end

    a_res_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_fire)
        else $error("result without a consumed byte");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pbp_pkg::PH_SKIP) |-> (r_skip_left != 2'd0))
        else $error("skip phase with empty skip count");

    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pbp_pkg::PH_DATA) |-> (r_entries_left != 9'd0))
        else $error("data phase with no entries left");

    a_end_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.event_res == pbp_pkg::EV_BLOCK_END)
        |=> (r_phase == pbp_pkg::PH_HDR_LO))
        else $error("block end did not return to header");

endmodule

>>> rtl/core/pbp_out_stage.sv
module pbp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pbp_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output pbp_pkg::t_result o_res
);

    logic             r_valid;
    pbp_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

>>> rtl/core/palette_block_parser_top.sv
// palette block parser: takes one byte of a palette block per transaction and
// emits a transaction for every completed r,g,b triplet (index, widened colour)
// and for the 0xffff end-of-block header. records start with a little-endian
// header (low byte start index, high byte count, count 0 meaning 256); header
// 0x0100 skips three bytes. a byte can be taken on every clock while results
// are drained: the byte sits in an input register, the parser state and
// result are worked out in one pass and written to an output register.
// back-pressure on the result side stalls the byte register only when the
// output register is full and not being drained.
module palette_block_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbp_byte_if.sink    i_byte,
    pbp_event_if.source o_event
);

    // input register to parser
    logic       in_valid;
    logic [7:0] in_byte;

    // parser to output register
    logic             res_valid;
    pbp_pkg::t_result res;
    pbp_pkg::t_result out_res;
    logic             out_free;
    logic             fire;

    // a held byte is consumed whenever the output register can take a result
    assign fire = in_valid && out_free;

    pbp_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_byte.valid),
        .o_ready     (i_byte.ready),
        .i_data_byte (i_byte.data_byte),
        .i_take      (fire),
        .o_valid     (in_valid),
        .o_data_byte (in_byte)
    );

    pbp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    pbp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_event.valid),
        .i_ready (o_event.ready),
        .o_res   (out_res)
    );

    // unpack the result onto the event channel
    assign o_event.event_res   = out_res.event_res;
    assign o_event.entry_index = out_res.entry_index;
    assign o_event.red         = out_res.red;
    assign o_event.green       = out_res.green;
    assign o_event.blue        = out_res.blue;

endmodule
